// ----- sv/imadec_pkg.sv -----
// ============================================================================
// imadec_pkg
// Shared types, constants and tables for the IMA ADPCM block decoder.
// ============================================================================
package imadec_pkg;

  localparam int CHANNELS  = 8;
  localparam int CH_W      = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int NIBBLES   = 8;
  localparam int NIB_W     = $clog2(NIBBLES);
  localparam int MAX_INDEX = 88;

  localparam logic KIND_HEADER = 1'b0;
  localparam logic KIND_DATA   = 1'b1;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load_hdr;
    logic load_data;
    logic step;
    logic last;
  } imadec_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic slot_free;
    logic chan_ok;
    logic kind_data;
  } imadec_sts_t;

  function automatic logic [14:0] step_table(input logic [6:0] idx);
    logic [14:0] v;
    case (idx)
      7'd0:  v = 15'd7;     7'd1:  v = 15'd8;     7'd2:  v = 15'd9;
      7'd3:  v = 15'd10;    7'd4:  v = 15'd11;    7'd5:  v = 15'd12;
      7'd6:  v = 15'd13;    7'd7:  v = 15'd14;    7'd8:  v = 15'd16;
      7'd9:  v = 15'd17;    7'd10: v = 15'd19;    7'd11: v = 15'd21;
      7'd12: v = 15'd23;    7'd13: v = 15'd25;    7'd14: v = 15'd28;
      7'd15: v = 15'd31;    7'd16: v = 15'd34;    7'd17: v = 15'd37;
      7'd18: v = 15'd41;    7'd19: v = 15'd45;    7'd20: v = 15'd50;
      7'd21: v = 15'd55;    7'd22: v = 15'd60;    7'd23: v = 15'd66;
      7'd24: v = 15'd73;    7'd25: v = 15'd80;    7'd26: v = 15'd88;
      7'd27: v = 15'd97;    7'd28: v = 15'd107;   7'd29: v = 15'd118;
      7'd30: v = 15'd130;   7'd31: v = 15'd143;   7'd32: v = 15'd157;
      7'd33: v = 15'd173;   7'd34: v = 15'd190;   7'd35: v = 15'd209;
      7'd36: v = 15'd230;   7'd37: v = 15'd253;   7'd38: v = 15'd279;
      7'd39: v = 15'd307;   7'd40: v = 15'd337;   7'd41: v = 15'd371;
      7'd42: v = 15'd408;   7'd43: v = 15'd449;   7'd44: v = 15'd494;
      7'd45: v = 15'd544;   7'd46: v = 15'd598;   7'd47: v = 15'd658;
      7'd48: v = 15'd724;   7'd49: v = 15'd796;   7'd50: v = 15'd876;
      7'd51: v = 15'd963;   7'd52: v = 15'd1060;  7'd53: v = 15'd1166;
      7'd54: v = 15'd1282;  7'd55: v = 15'd1411;  7'd56: v = 15'd1552;
      7'd57: v = 15'd1707;  7'd58: v = 15'd1878;  7'd59: v = 15'd2066;
      7'd60: v = 15'd2272;  7'd61: v = 15'd2499;  7'd62: v = 15'd2749;
      7'd63: v = 15'd3024;  7'd64: v = 15'd3327;  7'd65: v = 15'd3660;
      7'd66: v = 15'd4026;  7'd67: v = 15'd4428;  7'd68: v = 15'd4871;
      7'd69: v = 15'd5358;  7'd70: v = 15'd5894;  7'd71: v = 15'd6484;
      7'd72: v = 15'd7132;  7'd73: v = 15'd7845;  7'd74: v = 15'd8630;
      7'd75: v = 15'd9493;  7'd76: v = 15'd10442; 7'd77: v = 15'd11487;
      7'd78: v = 15'd12635; 7'd79: v = 15'd13899; 7'd80: v = 15'd15289;
      7'd81: v = 15'd16818; 7'd82: v = 15'd18500; 7'd83: v = 15'd20350;
      7'd84: v = 15'd22385; 7'd85: v = 15'd24623; 7'd86: v = 15'd27086;
      7'd87: v = 15'd29794; 7'd88: v = 15'd32767;
      default: v = 15'd32767;
    endcase
    return v;
  endfunction

  function automatic logic signed [7:0] index_adjust(input logic [2:0] mag);
    logic signed [7:0] v;
    case (mag)
      3'd4:    v = 8'sd2;
      3'd5:    v = 8'sd4;
      3'd6:    v = 8'sd6;
      3'd7:    v = 8'sd8;
      default: v = -8'sd1;
    endcase
    return v;
  endfunction

endpackage

// ----- sv/imadec_item_if.sv -----
// ============================================================================
// imadec_item_if
// Input channel of the decoder: one header or data item per transaction.
// ============================================================================
interface imadec_item_if;
  logic               valid;
  logic               ready;
  logic               kind;
  logic [2:0]         channel;
  logic signed [15:0] header_sample;
  logic [7:0]         header_index;
  logic [31:0]        data_word;

  modport source(output valid, kind, channel, header_sample, header_index, data_word,
                 input ready);
  modport sink(input valid, kind, channel, header_sample, header_index, data_word,
               output ready);
endinterface

// ----- sv/imadec_result_if.sv -----
// ============================================================================
// imadec_result_if
// Output channel of the decoder: one PCM sample per transaction.
// ============================================================================
interface imadec_result_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] sample;
  logic [2:0]         out_channel;
  logic               last;

  modport source(output valid, sample, out_channel, last, input ready);
  modport sink(input valid, sample, out_channel, last, output ready);
endinterface

// ----- sv/imadec_dp.sv -----
// ============================================================================
// imadec_dp
// Datapath: per-channel predictor and step index, the nibble decode step and
// the output register.
// ============================================================================
module imadec_dp (
  input  logic                      clk,
  input  logic                      rst,
  input  imadec_pkg::imadec_cmd_t   cmd,
  output imadec_pkg::imadec_sts_t   sts,
  input  logic                      kind,
  input  logic [2:0]                channel,
  input  logic signed [15:0]        header_sample,
  input  logic [7:0]                header_index,
  input  logic [31:0]               data_word,
  output logic                      res_valid,
  input  logic                      res_ready,
  output logic signed [15:0]        sample,
  output logic [2:0]                out_channel,
  output logic                      last
);
  import imadec_pkg::*;

  logic signed [15:0] predictor [CHANNELS];
  logic [6:0]         step_index [CHANNELS];

  logic signed [15:0] cur_s;
  logic [6:0]         cur_idx;
  logic [31:0]        word;
  logic [2:0]         cur_ch;

  logic [CH_W-1:0]    in_chi;
  logic [CH_W-1:0]    cur_chi;
  logic [6:0]         hdr_idx;
  logic [14:0]        step;
  logic [3:0]         code;
  logic [16:0]        diff;
  logic signed [17:0] sum;
  logic signed [15:0] s_next;
  logic signed [7:0]  idx_sum;
  logic [6:0]         idx_next;

  assign in_chi  = CH_W'(channel);
  assign cur_chi = CH_W'(cur_ch);
  assign hdr_idx = (header_index > 8'(MAX_INDEX)) ? 7'(MAX_INDEX) : header_index[6:0];

  assign sts.slot_free = !res_valid || res_ready;
  assign sts.chan_ok   = 32'(channel) < CHANNELS;
  assign sts.kind_data = (kind == KIND_DATA);

  // One nibble decode on the working state.
  assign code = word[3:0];
  assign step = step_table(cur_idx);
  always_comb begin
    diff = {5'd0, step[14:3]};
    if (code[2]) diff = diff + {2'd0, step};
    if (code[1]) diff = diff + {3'd0, step[14:1]};
    if (code[0]) diff = diff + {4'd0, step[14:2]};
    if (code[3]) begin
      sum = {{2{cur_s[15]}}, cur_s} - {1'b0, diff};
      s_next = (sum < -18'sd32768) ? -16'sd32768 : sum[15:0];
    end else begin
      sum = {{2{cur_s[15]}}, cur_s} + {1'b0, diff};
      s_next = (sum > 18'sd32767) ? 16'sd32767 : sum[15:0];
    end
    idx_sum = $signed({1'b0, cur_idx}) + index_adjust(code[2:0]);
    if (idx_sum < 8'sd0) begin
      idx_next = 7'd0;
    end else if (idx_sum > 8'(MAX_INDEX)) begin
      idx_next = 7'(MAX_INDEX);
    end else begin
      idx_next = idx_sum[6:0];
    end
  end

  // Channel state and output valid.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < CHANNELS; i++) begin
        predictor[i]  <= '0;
        step_index[i] <= '0;
      end
      res_valid <= 1'b0;
    end else begin
      if (cmd.load_hdr) begin
        predictor[in_chi]  <= header_sample;
        step_index[in_chi] <= hdr_idx;
      end
      if (cmd.step && cmd.last) begin
        predictor[cur_chi]  <= s_next;
        step_index[cur_chi] <= idx_next;
      end
      if (cmd.load_hdr || cmd.step) begin
        res_valid <= 1'b1;
      end else if (res_ready) begin
        res_valid <= 1'b0;
      end
    end
  end

  // Working registers and output payload.
  always_ff @(posedge clk) begin
    if (cmd.load_data) begin
      cur_s   <= predictor[in_chi];
      cur_idx <= step_index[in_chi];
      word    <= data_word;
      cur_ch  <= channel;
    end else if (cmd.step) begin
      cur_s   <= s_next;
      cur_idx <= idx_next;
      word    <= {4'd0, word[31:4]};
    end
    if (cmd.load_hdr) begin
      sample      <= header_sample;
      out_channel <= channel;
      last        <= 1'b1;
    end else if (cmd.step) begin
      sample      <= s_next;
      out_channel <= cur_ch;
      last        <= cmd.last;
    end
  end

endmodule

// ----- sv/imadec_ctrl.sv -----
// ============================================================================
// imadec_ctrl
// Controller: accepts items and sequences the eight nibble steps of a word.
// ============================================================================
module imadec_ctrl (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      item_valid,
  output logic                      item_ready,
  input  imadec_pkg::imadec_sts_t   sts,
  output imadec_pkg::imadec_cmd_t   cmd
);
  import imadec_pkg::*;

  localparam logic ST_IDLE   = 1'b0;
  localparam logic ST_DECODE = 1'b1;

  logic             state;
  logic             state_next;
  logic [NIB_W-1:0] count;
  logic [NIB_W-1:0] count_next;

  always_comb begin
    cmd        = '0;
    item_ready = 1'b0;
    state_next = state;
    count_next = count;
    case (state)
      ST_IDLE: begin
        item_ready = sts.slot_free;
        if (item_valid && sts.slot_free && sts.chan_ok) begin
          if (sts.kind_data) begin
            cmd.load_data = 1'b1;
            count_next    = '0;
            state_next    = ST_DECODE;
          end else begin
            cmd.load_hdr = 1'b1;
          end
        end
      end
      ST_DECODE: begin
        if (sts.slot_free) begin
          cmd.step = 1'b1;
          cmd.last = (count == NIB_W'(NIBBLES - 1));
          if (cmd.last) begin
            state_next = ST_IDLE;
          end else begin
            count_next = count + 1'b1;
          end
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      count <= '0;
    end else begin
      state <= state_next;
      count <= count_next;
    end
  end

endmodule

// ----- sv/ima_adpcm_block_decoder.sv -----
// ============================================================================
// ima_adpcm_block_decoder
// IMA ADPCM decoder for 4-bit codes in WAV block layout, eight channels.
// ============================================================================
// The item channel carries block headers (kind 0) and data words (kind 1),
// each tagged with a channel. A header transaction loads that channel's
// predictor and step index (an index above 88 is held at 88) and returns the
// predictor as one sample with last set. A data transaction carries eight
// 4-bit codes, decoded lowest nibble first, and returns eight samples on the
// result channel, the eighth with last set. Items for a channel number not
// below the channel count are taken and dropped without any result.
// A data word is loaded into working registers and its nibbles are then decoded
// one after another, since each nibble depends on the predictor and index
// left by the one before it and all share one decode unit. A header's sample
// is in the output register right after its item is taken; a data word's
// first sample is registered by the first nibble step after the word loads.
// A single output register holds the newest sample; while the controller is
// idle a new item is taken as long as that register is empty or being emptied
// in the same cycle, so a stalled receiver simply freezes the decode sequence.
// Synchronous reset clears all predictors and step indexes to zero, empties
// the output register and returns the controller to idle.
// ============================================================================
module ima_adpcm_block_decoder (
  input  logic            clk,
  input  logic            rst,
  imadec_item_if.sink     item,
  imadec_result_if.source result
);
  import imadec_pkg::*;

  imadec_cmd_t cmd;
  imadec_sts_t sts;

  // The controller owns the handshake on the item side and the nibble count.
  imadec_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item.valid),
    .item_ready (item.ready),
    .sts        (sts),
    .cmd        (cmd)
  );

  // The datapath holds channel state, the decode step and the result register.
  imadec_dp u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .sts           (sts),
    .kind          (item.kind),
    .channel       (item.channel),
    .header_sample (item.header_sample),
    .header_index  (item.header_index),
    .data_word     (item.data_word),
    .res_valid     (result.valid),
    .res_ready     (result.ready),
    .sample        (result.sample),
    .out_channel   (result.out_channel),
    .last          (result.last)
  );

endmodule
